/* rtl/epmm_pkg.sv */
package epmm_pkg;

    // pipeline depth from request to result register
    localparam int unsigned LAT = 18;
    // depth of the sine/cosine unit, entry register to its output register
    localparam int unsigned SC_LAT = 13;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [13:0] OCTANT  = 14'd8192;
    localparam logic [14:0] QUARTER = 15'd16384;

    // floor(v / d) = (v * M) >> K for v < 2^30, K = 30 + ceil(log2 d)
    localparam int unsigned DIV72_K = 37;
    localparam int unsigned DIV90_K = 37;
    localparam int unsigned DIV42_K = 36;
    localparam int unsigned DIV56_K = 36;
    localparam int unsigned DIV20_K = 35;
    localparam int unsigned DIV30_K = 35;
    localparam int unsigned DIV6_K  = 33;
    localparam int unsigned DIV12_K = 34;
    localparam logic [30:0] DIV72_M = 31'(((64'd1 << DIV72_K) + 64'd71) / 64'd72);
    localparam logic [30:0] DIV90_M = 31'(((64'd1 << DIV90_K) + 64'd89) / 64'd90);
    localparam logic [30:0] DIV42_M = 31'(((64'd1 << DIV42_K) + 64'd41) / 64'd42);
    localparam logic [30:0] DIV56_M = 31'(((64'd1 << DIV56_K) + 64'd55) / 64'd56);
    localparam logic [30:0] DIV20_M = 31'(((64'd1 << DIV20_K) + 64'd19) / 64'd20);
    localparam logic [30:0] DIV30_M = 31'(((64'd1 << DIV30_K) + 64'd29) / 64'd30);
    localparam logic [30:0] DIV6_M  = 31'(((64'd1 << DIV6_K) + 64'd5) / 64'd6);
    localparam logic [30:0] DIV12_M = 31'(((64'd1 << DIV12_K) + 64'd11) / 64'd12);

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        angle_x;
        logic [15:0]        angle_y;
        logic [15:0]        angle_z;
        logic [30:0]        scale_factor;
    } t_pose;

    typedef struct packed {
        logic signed [31:0] m_r0c0;
        logic signed [31:0] m_r0c1;
        logic signed [31:0] m_r0c2;
        logic signed [31:0] m_r1c0;
        logic signed [31:0] m_r1c1;
        logic signed [31:0] m_r1c2;
        logic signed [31:0] m_r2c0;
        logic signed [31:0] m_r2c1;
        logic signed [31:0] m_r2c2;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } t_mat;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } t_sincos;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_trans;

endpackage

/* rtl/euler_pose_to_model_matrix.sv */
// channel   direction  handshake                        payload
// pose      in         i_pose_valid / o_pose_ready      i_pose (epmm_pkg::t_pose)
// matrix    out        o_mat_valid / i_mat_ready        o_mat  (epmm_pkg::t_mat)
//
// one pose per cycle while the result register is not stalled
// most of the depth is the sine/cosine series, 13 stages
// reset clears only the valid bits of the pipeline
// a stalled result holds the whole pipeline; o_pose_ready is low only while the
// result register is full and not taken
module euler_pose_to_model_matrix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pose_valid,
    output logic              o_pose_ready,
    input  epmm_pkg::t_pose   i_pose,
    output logic              o_mat_valid,
    input  logic              i_mat_ready,
    output epmm_pkg::t_mat    o_mat
);

    localparam int unsigned L  = epmm_pkg::LAT;

    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return 32'((p + 64'sd536870912) >>> 30);
    endfunction

    function automatic logic signed [31:0] sat_q30(input logic signed [63:0] e);
        logic signed [33:0] v;
        v = 34'((e + 64'sd536870912) >>> 30);
        if (v > 34'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -34'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return 32'(v);
        end
    endfunction

    logic              w_en;
    logic [L-1:0]      r_vld;

    epmm_pkg::t_sincos w_scx, w_scy, w_scz;

    epmm_pkg::t_trans  r_pos [0:L-2];
    logic [30:0]       r_scl [0:L-3];

    logic signed [31:0] r_sxsy, r_cxsy, r_cycz, r_cysz, r_cxsz, r_cxcz;
    logic signed [31:0] r_sxcy, r_sxsz, r_sxcz, r_cxcy, r_sy1, r_sz1, r_cz1;
    logic signed [31:0] r_sxsycz, r_sxsysz, r_cxsycz, r_cxsysz;
    logic signed [31:0] r_cycz2, r_cysz2, r_cxsz2, r_cxcz2, r_sxcy2, r_sxsz2;
    logic signed [31:0] r_sxcz2, r_cxcy2, r_sy2;
    logic signed [32:0] r_m [0:8];
    logic signed [63:0] r_e [0:8];
    logic signed [63:0] w_prod [0:8];
    logic signed [31:0] w_scl;
    epmm_pkg::t_mat     r_out;

    assign w_en         = ~r_vld[L-1] | i_mat_ready;
    assign o_pose_ready = w_en;
    assign o_mat_valid  = r_vld[L-1];
    assign o_mat        = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_pose_valid};
        end
    end

    epmm_sincos u_sc_x (.i_clk(i_clk), .i_en(w_en), .i_angle(i_pose.angle_x), .o_sc(w_scx));
    epmm_sincos u_sc_y (.i_clk(i_clk), .i_en(w_en), .i_angle(i_pose.angle_y), .o_sc(w_scy));
    epmm_sincos u_sc_z (.i_clk(i_clk), .i_en(w_en), .i_angle(i_pose.angle_z), .o_sc(w_scz));

    assign w_scl = $signed({1'b0, r_scl[L-3]});

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_prod[i] = r_m[i] * w_scl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pos[0] <= '{x: i_pose.pos_x, y: i_pose.pos_y, z: i_pose.pos_z};
            r_scl[0] <= i_pose.scale_factor;
            for (int i = 1; i < L - 1; i++) begin
                r_pos[i] <= r_pos[i-1];
            end
            for (int i = 1; i < L - 2; i++) begin
                r_scl[i] <= r_scl[i-1];
            end

            // first row of products
            r_sxsy <= mul_q30(w_scx.s, w_scy.s);
            r_cxsy <= mul_q30(w_scx.c, w_scy.s);
            r_cycz <= mul_q30(w_scy.c, w_scz.c);
            r_cysz <= mul_q30(w_scy.c, w_scz.s);
            r_cxsz <= mul_q30(w_scx.c, w_scz.s);
            r_cxcz <= mul_q30(w_scx.c, w_scz.c);
            r_sxcy <= mul_q30(w_scx.s, w_scy.c);
            r_sxsz <= mul_q30(w_scx.s, w_scz.s);
            r_sxcz <= mul_q30(w_scx.s, w_scz.c);
            r_cxcy <= mul_q30(w_scx.c, w_scy.c);
            r_sy1  <= w_scy.s;
            r_sz1  <= w_scz.s;
            r_cz1  <= w_scz.c;

            // triple products
            r_sxsycz <= mul_q30(r_sxsy, r_cz1);
            r_sxsysz <= mul_q30(r_sxsy, r_sz1);
            r_cxsycz <= mul_q30(r_cxsy, r_cz1);
            r_cxsysz <= mul_q30(r_cxsy, r_sz1);
            r_cycz2  <= r_cycz;
            r_cysz2  <= r_cysz;
            r_cxsz2  <= r_cxsz;
            r_cxcz2  <= r_cxcz;
            r_sxcy2  <= r_sxcy;
            r_sxsz2  <= r_sxsz;
            r_sxcz2  <= r_sxcz;
            r_cxcy2  <= r_cxcy;
            r_sy2    <= r_sy1;

            // rotation entries, one guard bit for the sums
            r_m[0] <= 33'(r_cycz2);
            r_m[1] <= -33'(r_cysz2);
            r_m[2] <= 33'(r_sy2);
            r_m[3] <= 33'(r_cxsz2) + 33'(r_sxsycz);
            r_m[4] <= 33'(r_cxcz2) - 33'(r_sxsysz);
            r_m[5] <= -33'(r_sxcy2);
            r_m[6] <= 33'(r_sxsz2) - 33'(r_cxsycz);
            r_m[7] <= 33'(r_sxcz2) + 33'(r_cxsysz);
            r_m[8] <= 33'(r_cxcy2);

            for (int i = 0; i < 9; i++) begin
                r_e[i] <= w_prod[i];
            end

            r_out.m_r0c0  <= sat_q30(r_e[0]);
            r_out.m_r0c1  <= sat_q30(r_e[1]);
            r_out.m_r0c2  <= sat_q30(r_e[2]);
            r_out.m_r1c0  <= sat_q30(r_e[3]);
            r_out.m_r1c1  <= sat_q30(r_e[4]);
            r_out.m_r1c2  <= sat_q30(r_e[5]);
            r_out.m_r2c0  <= sat_q30(r_e[6]);
            r_out.m_r2c1  <= sat_q30(r_e[7]);
            r_out.m_r2c2  <= sat_q30(r_e[8]);
            r_out.trans_x <= r_pos[L-2].x;
            r_out.trans_y <= r_pos[L-2].y;
            r_out.trans_z <= r_pos[L-2].z;
        end
    end

endmodule

/* rtl/epmm_sincos.sv */
module epmm_sincos (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [15:0]          i_angle,
    output epmm_pkg::t_sincos    o_sc
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    function automatic logic [29:0] mul_rnd(input logic [29:0] v, input logic [30:0] a);
        logic [60:0] p;
        p = 61'(v) * 61'(a);
        return 30'((p + (61'd1 << 29)) >> 30);
    endfunction

    function automatic logic [29:0] div_c(input logic [29:0] v, input logic [30:0] m,
                                          input int unsigned k);
        logic [60:0] p;
        p = 61'(v) * 61'(m);
        return 30'(p >> k);
    endfunction

    logic [13:0] w_r;
    logic        w_sw;
    logic [13:0] w_t;
    logic [45:0] w_px;
    logic [59:0] w_xx;

    logic [13:0] r_t;
    logic        r_sw [0:11];
    logic [1:0]  r_q  [0:11];
    logic [29:0] r_x  [1:9];
    logic [29:0] r_sq [2:9];
    logic [30:0] r_a3, r_a5, r_a7, r_a9, r_b3, r_b5, r_b7, r_b9;
    logic [29:0] r_pa4, r_pa6, r_pa8, r_pb4, r_pb6, r_pb8, r_pb10;
    logic [29:0] r_s10, r_s11;
    logic [30:0] r_c11;
    epmm_pkg::t_sincos r_out;

    logic [30:0]        w_sk, w_ck;
    logic signed [31:0] w_ps, w_pc;
    epmm_pkg::t_sincos  n_out;

    assign w_r  = i_angle[13:0];
    assign w_sw = (w_r > epmm_pkg::OCTANT);
    assign w_t  = w_sw ? 14'(epmm_pkg::QUARTER - {1'b0, w_r}) : w_r;
    assign w_px = 46'(r_t) * 46'(epmm_pkg::PI_Q30) + 46'd16384;
    assign w_xx = 60'(r_x[1]) * 60'(r_x[1]) + 60'd536870912;

    // past the octant sine and cosine trade places, then the quadrant turns them
    always_comb begin
        w_sk = r_sw[11] ? r_c11 : {1'b0, r_s11};
        w_ck = r_sw[11] ? {1'b0, r_s11} : r_c11;
        w_ps = $signed({1'b0, w_sk});
        w_pc = $signed({1'b0, w_ck});
        unique case (r_q[11])
            QUAD_0: begin
                n_out.s = w_ps;
                n_out.c = w_pc;
            end
            QUAD_1: begin
                n_out.s = w_pc;
                n_out.c = -w_ps;
            end
            QUAD_2: begin
                n_out.s = -w_ps;
                n_out.c = -w_pc;
            end
            QUAD_3: begin
                n_out.s = -w_pc;
                n_out.c = w_ps;
            end
            default: begin
                n_out.s = w_ps;
                n_out.c = w_pc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= w_t;
            r_sw[0] <= w_sw;
            r_q[0]  <= i_angle[15:14];
            for (int i = 1; i < 12; i++) begin
                r_sw[i] <= r_sw[i-1];
                r_q[i]  <= r_q[i-1];
            end
            r_x[1] <= 30'(w_px >> 15);
            for (int i = 2; i < 10; i++) begin
                r_x[i] <= r_x[i-1];
            end
            r_sq[2] <= 30'(w_xx >> 30);
            for (int i = 3; i < 10; i++) begin
                r_sq[i] <= r_sq[i-1];
            end
            // sine series runs in a, cosine series in b, innermost term first
            r_a3   <= epmm_pkg::Q30_ONE
                      - {1'b0, div_c(r_sq[2], epmm_pkg::DIV72_M, epmm_pkg::DIV72_K)};
            r_b3   <= epmm_pkg::Q30_ONE
                      - {1'b0, div_c(r_sq[2], epmm_pkg::DIV90_M, epmm_pkg::DIV90_K)};
            r_pa4  <= mul_rnd(r_sq[3], r_a3);
            r_pb4  <= mul_rnd(r_sq[3], r_b3);
            r_a5   <= epmm_pkg::Q30_ONE
                      - {1'b0, div_c(r_pa4, epmm_pkg::DIV42_M, epmm_pkg::DIV42_K)};
            r_b5   <= epmm_pkg::Q30_ONE
                      - {1'b0, div_c(r_pb4, epmm_pkg::DIV56_M, epmm_pkg::DIV56_K)};
            r_pa6  <= mul_rnd(r_sq[5], r_a5);
            r_pb6  <= mul_rnd(r_sq[5], r_b5);
            r_a7   <= epmm_pkg::Q30_ONE
                      - {1'b0, div_c(r_pa6, epmm_pkg::DIV20_M, epmm_pkg::DIV20_K)};
            r_b7   <= epmm_pkg::Q30_ONE
                      - {1'b0, div_c(r_pb6, epmm_pkg::DIV30_M, epmm_pkg::DIV30_K)};
            r_pa8  <= mul_rnd(r_sq[7], r_a7);
            r_pb8  <= mul_rnd(r_sq[7], r_b7);
            r_a9   <= epmm_pkg::Q30_ONE
                      - {1'b0, div_c(r_pa8, epmm_pkg::DIV6_M, epmm_pkg::DIV6_K)};
            r_b9   <= epmm_pkg::Q30_ONE
                      - {1'b0, div_c(r_pb8, epmm_pkg::DIV12_M, epmm_pkg::DIV12_K)};
            r_s10  <= mul_rnd(r_x[9], r_a9);
            r_pb10 <= mul_rnd(r_sq[9], r_b9);
            r_s11  <= r_s10;
            r_c11  <= epmm_pkg::Q30_ONE - {2'b00, r_pb10[29:1]};
            r_out  <= n_out;
        end
    end

    assign o_sc = r_out;

endmodule
